// File: rtl/segment_intersection_macros.svh
// Assertion macros used by the segment intersection checker
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

// Concurrent assertion clocked on clk, off during reset
`define SEGI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, but also checked while reset is asserted
`define SEGI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/segi_pkg.sv
// Package: types, constants and helpers of the segment intersection block
package segi_pkg;

	localparam int COORD_BITS = 32;
	localparam int CW         = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int DW         = 67;  // determinant and numerators, signed
	localparam int NW         = 99;  // numerator times coordinate span
	localparam int DIV_STEPS  = 32;  // quotient bits, one per cell
	localparam logic [DW-1:0] PAR_LIMIT = DW'(4295);

	// one axis of the divider: partial remainder and shared dividend/quotient word
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [31:0]   w;
	} axis_t;

	// everything a divider cell passes to its neighbor
	typedef struct packed {
		logic          hit;
		logic [DW-1:0] d;
		logic [31:0]   sx;
		logic [31:0]   sy;
		logic          nx;
		logic          ny;
		axis_t         ax;
		axis_t         ay;
	} div_t;

	// low CW bits of a field, sign extended
	function automatic logic signed [32:0] coord(input logic [31:0] v);
		logic signed [31:0] t;
		t = $signed(v << (32 - CW)) >>> (32 - CW);
		return {t[31], t};
	endfunction

endpackage

// File: rtl/segment_intersection.sv
// Top level: 2D segment intersection pipeline with a chain of divider cells
//
// Input channel: in_valid / in_stall with eight signed Q16.16 coordinates,
// segment A (first_*) and segment B (second_*). A transfer happens on a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with hit, cross_x and cross_y;
// cross_x and cross_y are zero on a miss (parallel or no crossing).
// The pipeline has six front stages (differences, cross products,
// inside test, dividend products), 32 divider cells that each produce one
// quotient bit, and the output register.
// Throughput is one segment pair per cycle while no result waits on a stall;
// the divider chain holds up to 32 pairs in flight.
// Reset (arst_n low) clears all stage valids; no result is pending after it.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; it drops as soon as the result moves.
module segment_intersection (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] first_start_x,
	input  logic [31:0] first_start_y,
	input  logic [31:0] first_end_x,
	input  logic [31:0] first_end_y,
	input  logic [31:0] second_start_x,
	input  logic [31:0] second_start_y,
	input  logic [31:0] second_end_x,
	input  logic [31:0] second_end_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [31:0] cross_x,
	output logic [31:0] cross_y
);
	import segi_pkg::*;

	logic en;
	logic  cv [0:DIV_STEPS];
	div_t  cd [0:DIV_STEPS];
	logic [31:0] stx, sty;
	div_t last;

	// pipeline advances unless a result waits on a stalled receiver
	assign in_stall = out_valid & out_stall;
	assign en       = ~in_stall;

	segi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.ax0      (first_start_x),
		.ay0      (first_start_y),
		.ax1      (first_end_x),
		.ay1      (first_end_y),
		.bx0      (second_start_x),
		.by0      (second_start_y),
		.bx1      (second_end_x),
		.by1      (second_end_y),
		.valid_o  (cv[0]),
		.data_o   (cd[0])
	);

	// divider chain
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		segi_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (cv[i]),
			.data_i  (cd[i]),
			.valid_q (cv[i+1]),
			.data_q  (cd[i+1])
		);
	end

	// apply span sign and add the start point
	always_comb begin
		last = cd[DIV_STEPS];
		stx  = last.nx ? (32'd0 - last.ax.w) : last.ax.w;
		sty  = last.ny ? (32'd0 - last.ay.w) : last.ay.w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= cv[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= last.hit;
			cross_x <= last.hit ? (last.sx + stx) : '0;
			cross_y <= last.hit ? (last.sy + sty) : '0;
		end
	end

endmodule

// File: rtl/segi_front.sv
// Front end: differences, cross products, inside test and dividend products
module segi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [31:0]       ax0,
	input  logic [31:0]       ay0,
	input  logic [31:0]       ax1,
	input  logic [31:0]       ay1,
	input  logic [31:0]       bx0,
	input  logic [31:0]       by0,
	input  logic [31:0]       bx1,
	input  logic [31:0]       by1,
	output logic              valid_o,
	output segi_pkg::div_t    data_o
);
	import segi_pkg::*;

	logic [6:1] v_q;

	// stage 1: coordinate differences
	logic signed [32:0] dax_s1, dby_s1, day_s1, dbx_s1, abx_s1, aby_s1, ex_s1, ey_s1;
	logic [31:0] sx_s1, sy_s1;
	// stage 2: products
	logic signed [65:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2;
	logic signed [32:0] ex_s2, ey_s2;
	logic [31:0] sx_s2, sy_s2;
	// stage 3: determinant, numerators, spans
	logic signed [DW-1:0] d_s3, tn_s3, un_s3;
	logic [31:0] mx_s3, my_s3, sx_s3, sy_s3;
	logic nx_s3, ny_s3;
	// stage 4: normalized values and hit
	logic [DW-1:0] d_s4, tn_s4;
	logic hit_s4;
	logic [31:0] mx_s4, my_s4, sx_s4, sy_s4;
	logic nx_s4, ny_s4;
	// stage 5: partial products
	logic [63:0] px0_s5, px1_s5, py0_s5, py1_s5;
	logic [34:0] px2_s5, py2_s5;
	logic [DW-1:0] d_s5;
	logic hit_s5;
	logic [31:0] sx_s5, sy_s5;
	logic nx_s5, ny_s5;
	// stage 6: full dividends
	logic [NW-1:0] nxf_s6, nyf_s6;
	logic [DW-1:0] d_s6;
	logic hit_s6;
	logic [31:0] sx_s6, sy_s6;
	logic nx_s6, ny_s6;

	logic signed [32:0] cax0, cay0, cax1, cay1, cbx0, cby0, cbx1, cby1;
	logic signed [32:0] nex, ney;
	logic [DW-1:0] da, ta, ua;
	logic hit_c;

	assign cax0 = coord(ax0);
	assign cay0 = coord(ay0);
	assign cax1 = coord(ax1);
	assign cay1 = coord(ay1);
	assign cbx0 = coord(bx0);
	assign cby0 = coord(by0);
	assign cbx1 = coord(bx1);
	assign cby1 = coord(by1);

	assign nex = -ex_s2;
	assign ney = -ey_s2;

	// sign normalization and inside test
	always_comb begin
		da = d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
		ta = d_s3[DW-1] ? DW'(-tn_s3) : DW'(tn_s3);
		ua = d_s3[DW-1] ? DW'(-un_s3) : DW'(un_s3);
		hit_c = (da >= PAR_LIMIT) && !ta[DW-1] && !ua[DW-1] && (ta <= da) && (ua <= da);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:1], in_valid};
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (en) begin
			dax_s1 <= cax0 - cax1;
			dby_s1 <= cby0 - cby1;
			day_s1 <= cay0 - cay1;
			dbx_s1 <= cbx0 - cbx1;
			abx_s1 <= cax0 - cbx0;
			aby_s1 <= cay0 - cby0;
			ex_s1  <= cax1 - cax0;
			ey_s1  <= cay1 - cay0;
			sx_s1  <= cax0[31:0];
			sy_s1  <= cay0[31:0];

			p1_s2 <= dax_s1 * dby_s1;
			p2_s2 <= day_s1 * dbx_s1;
			p3_s2 <= abx_s1 * dby_s1;
			p4_s2 <= aby_s1 * dbx_s1;
			p5_s2 <= abx_s1 * day_s1;
			p6_s2 <= aby_s1 * dax_s1;
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;

			d_s3  <= {p1_s2[65], p1_s2} - {p2_s2[65], p2_s2};
			tn_s3 <= {p3_s2[65], p3_s2} - {p4_s2[65], p4_s2};
			un_s3 <= {p5_s2[65], p5_s2} - {p6_s2[65], p6_s2};
			nx_s3 <= ex_s2[32];
			ny_s3 <= ey_s2[32];
			mx_s3 <= ex_s2[32] ? nex[31:0] : ex_s2[31:0];
			my_s3 <= ey_s2[32] ? ney[31:0] : ey_s2[31:0];
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;

			// a miss runs through the divider as 0 / 1
			hit_s4 <= hit_c;
			d_s4   <= hit_c ? da : DW'(1);
			tn_s4  <= hit_c ? ta : '0;
			mx_s4  <= mx_s3;
			my_s4  <= my_s3;
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;

			px0_s5 <= tn_s4[31:0] * mx_s4;
			px1_s5 <= tn_s4[63:32] * mx_s4;
			px2_s5 <= tn_s4[66:64] * mx_s4;
			py0_s5 <= tn_s4[31:0] * my_s4;
			py1_s5 <= tn_s4[63:32] * my_s4;
			py2_s5 <= tn_s4[66:64] * my_s4;
			d_s5   <= d_s4;
			hit_s5 <= hit_s4;
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			sx_s5  <= sx_s4;
			sy_s5  <= sy_s4;

			nxf_s6 <= NW'(px0_s5) + (NW'(px1_s5) << 32) + (NW'(px2_s5) << 64);
			nyf_s6 <= NW'(py0_s5) + (NW'(py1_s5) << 32) + (NW'(py2_s5) << 64);
			d_s6   <= d_s5;
			hit_s6 <= hit_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			sx_s6  <= sx_s5;
			sy_s6  <= sy_s5;
		end
	end

	// divider entry: high part is already below d
	always_comb begin
		data_o.hit    = hit_s6;
		data_o.d      = d_s6;
		data_o.sx     = sx_s6;
		data_o.sy     = sy_s6;
		data_o.nx     = nx_s6;
		data_o.ny     = ny_s6;
		data_o.ax.rem = nxf_s6[NW-1:32];
		data_o.ax.w   = nxf_s6[31:0];
		data_o.ay.rem = nyf_s6[NW-1:32];
		data_o.ay.w   = nyf_s6[31:0];
	end

	assign valid_o = v_q[6];

endmodule

// File: rtl/segi_div_cell.sv
// Divider cell: one restoring quotient bit for both axes
module segi_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           valid_i,
	input  segi_pkg::div_t data_i,
	output logic           valid_q,
	output segi_pkg::div_t data_q
);
	import segi_pkg::*;

	logic [DW:0] dz, rx, ry, fx, fy;
	logic gx, gy;
	div_t nxt;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		dz  = {1'b0, data_i.d};
		rx  = {data_i.ax.rem, data_i.ax.w[31]};
		ry  = {data_i.ay.rem, data_i.ay.w[31]};
		gx  = rx >= dz;
		gy  = ry >= dz;
		fx  = rx - dz;
		fy  = ry - dz;
		nxt = data_i;
		nxt.ax.rem = gx ? fx[DW-1:0] : rx[DW-1:0];
		nxt.ay.rem = gy ? fy[DW-1:0] : ry[DW-1:0];
		nxt.ax.w   = {data_i.ax.w[30:0], gx};
		nxt.ay.w   = {data_i.ay.w[30:0], gy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

endmodule

// File: rtl/segi_checker.sv
// Port checker for the segment intersection block, bound to the top level
`include "segment_intersection_macros.svh"

module segi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [31:0] cross_x,
	input logic [31:0] cross_y
);

	// a stalled result stays offered and unchanged
	`SEGI_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(cross_x) && $stable(cross_y) && $stable(hit), "stalled result changed")
	// a miss carries a zero point
	`SEGI_ASSERT(a_miss_zero, out_valid && !hit |-> cross_x == 32'd0 && cross_y == 32'd0, "miss with nonzero point")
	// input is held off exactly while a result waits on a stall
	`SEGI_ASSERT(a_in_stall, in_stall == (out_valid && out_stall), "input stall mismatch")
	// nothing is offered once reset has been seen at an edge
	`SEGI_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "result offered during reset")

endmodule

bind segment_intersection segi_checker u_segi_checker (.*);
